// ===== rtl/core/cltok_pkg.sv =====
// ============================================================================
// cltok_pkg: shared types and constants for the token scanner
// Holds the scan-mode enum, token kind codes, error codes and the packed
// result record.
// ============================================================================
package cltok_pkg;

    typedef enum logic [4:0] {
        M_IDLE     = 5'd0,
        M_NAME     = 5'd1,
        M_DOT      = 5'd2,
        M_ZERO     = 5'd3,
        M_RUN      = 5'd4,
        M_RUN_OVF  = 5'd5,
        M_INT      = 5'd6,
        M_INT_SKIP = 5'd7,
        M_FRAC     = 5'd8,
        M_EXP0     = 5'd9,
        M_EXP1     = 5'd10,
        M_EXPD     = 5'd11,
        M_CH_OPEN  = 5'd12,
        M_CH_ESC   = 5'd13,
        M_CH_CLOSE = 5'd14,
        M_ST_BODY  = 5'd15,
        M_ST_ESC   = 5'd16,
        M_OP       = 5'd17
    } mode_t;

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_DOT    = 6'd9;
    localparam logic [5:0] K_INT    = 6'd13;
    localparam logic [5:0] K_FLOAT  = 6'd14;
    localparam logic [5:0] K_STR    = 6'd15;
    localparam logic [5:0] K_NAME   = 6'd16;
    localparam logic [5:0] K_LSHIFT = 6'd23;
    localparam logic [5:0] K_RSHIFT = 6'd24;
    localparam logic [5:0] K_NONE   = 6'd63;

    localparam logic [2:0] MOD_NONE = 3'd0;
    localparam logic [2:0] MOD_HEX  = 3'd1;
    localparam logic [2:0] MOD_OCT  = 3'd2;
    localparam logic [2:0] MOD_BIN  = 3'd3;
    localparam logic [2:0] MOD_CHAR = 3'd4;

    localparam logic [3:0] E_NONE     = 4'd0;
    localparam logic [3:0] E_BAD_CHAR = 4'd1;
    localparam logic [3:0] E_DIGIT    = 4'd2;
    localparam logic [3:0] E_OVF      = 4'd3;
    localparam logic [3:0] E_EMPTY_CH = 4'd4;
    localparam logic [3:0] E_NL_CH    = 4'd5;
    localparam logic [3:0] E_BAD_ESC  = 4'd6;
    localparam logic [3:0] E_NO_CLOSE = 4'd7;
    localparam logic [3:0] E_NL_STR   = 4'd8;
    localparam logic [3:0] E_EOF_STR  = 4'd9;
    localparam logic [3:0] E_NO_EXP   = 4'd10;

    typedef struct packed {
        logic [5:0]  token_code;
        logic [2:0]  literal_mod;
        logic [63:0] int_value;
        logic [15:0] start_offset;
        logic [15:0] end_offset;
        logic [3:0]  error_code;
    } token_t;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
            || (c == 8'h5f);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd16;
        if (is_dig(c))
        begin
            r = 5'(c - 8'h30);
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            r = 5'(c - 8'h57);
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            r = 5'(c - 8'h37);
        end
        return r;
    endfunction

    function automatic logic [8:0] esc_val(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h6e: r = {1'b1, 8'd10};
            8'h72: r = {1'b1, 8'd13};
            8'h74: r = {1'b1, 8'd9};
            8'h76: r = {1'b1, 8'd11};
            8'h62: r = {1'b1, 8'd8};
            8'h61: r = {1'b1, 8'd7};
            8'h30: r = {1'b1, 8'd0};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] r;
        case (c)
            8'h28: r = 6'd2;
            8'h29: r = 6'd3;
            8'h7b: r = 6'd4;
            8'h7d: r = 6'd5;
            8'h5b: r = 6'd6;
            8'h5d: r = 6'd7;
            8'h2c: r = 6'd8;
            8'h3f: r = 6'd10;
            8'h3b: r = 6'd11;
            8'h7e: r = 6'd17;
            8'h21: r = 6'd18;
            default: r = K_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] c);
        logic [5:0] r;
        case (c)
            8'h3a: r = 6'd1;
            8'h3d: r = 6'd37;
            8'h5e: r = 6'd27;
            8'h2a: r = 6'd19;
            8'h2f: r = 6'd20;
            8'h25: r = 6'd21;
            8'h2b: r = 6'd25;
            8'h2d: r = 6'd26;
            8'h26: r = 6'd22;
            8'h7c: r = 6'd28;
            8'h3c: r = 6'd31;
            8'h3e: r = 6'd32;
            default: r = K_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] op_next(input logic [5:0] k, input logic [7:0] c);
        logic [5:0] r;
        r = K_NONE;
        if (c == 8'h3d)
        begin
            case (k)
                6'd1: r = 6'd50;
                6'd37: r = 6'd29;
                6'd27: r = 6'd42;
                6'd19: r = 6'd45;
                6'd20: r = 6'd46;
                6'd21: r = 6'd47;
                6'd25: r = 6'd38;
                6'd26: r = 6'd39;
                6'd22: r = 6'd41;
                6'd28: r = 6'd40;
                6'd31: r = 6'd33;
                6'd32: r = 6'd34;
                K_LSHIFT: r = 6'd43;
                K_RSHIFT: r = 6'd44;
                default: r = K_NONE;
            endcase
        end
        else if (k == 6'd25 && c == 8'h2b) r = 6'd48;
        else if (k == 6'd26 && c == 8'h2d) r = 6'd49;
        else if (k == 6'd22 && c == 8'h26) r = 6'd35;
        else if (k == 6'd28 && c == 8'h7c) r = 6'd36;
        else if (k == 6'd31 && c == 8'h3c) r = K_LSHIFT;
        else if (k == 6'd32 && c == 8'h3e) r = K_RSHIFT;
        return r;
    endfunction

endpackage

// ===== rtl/core/c_like_token_scanner.sv =====
// ============================================================================
// c_like_token_scanner: streaming maximal-munch tokenizer
// Top level: byte input, scanner state machine and token output buffer.
// ============================================================================
// One source byte is taken per item and the block takes a new byte every cycle
// while the output side keeps up. Tokens are registered in the result buffer and
// appear at the output in the cycle after the byte that completes them. A byte
// that completes two tokens holds the input while the second token leaves. Tokens
// leave from a two-entry result register, and any token still waiting there at a
// clock edge holds the input, whether or not the next byte produces a token.
module c_like_token_scanner #(
    parameter int OFFSET_WIDTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // source_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // token_code[5:0], literal_mod[8:6], int_value[72:9], start_offset[88:73],
    // end_offset[104:89], error_code[108:105], zero fill [111:109]
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tlast    // last_of_run
);

    logic              step, can_load, load;
    logic [1:0]        n_tok;
    cltok_pkg::token_t tok0, tok1, otok;

    assign s_axis_tready = can_load;
    assign step = s_axis_tvalid && s_axis_tready;
    assign load = step && (n_tok != 2'd0);

    cltok_fsm #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_fsm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .c     (s_axis_tdata),
        .n_tok (n_tok),
        .tok0  (tok0),
        .tok1  (tok1)
    );

    cltok_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .n_in      (n_tok),
        .tok0      (tok0),
        .tok1      (tok1),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tok   (otok),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, otok.error_code, otok.end_offset, otok.start_offset,
                           otok.int_value, otok.literal_mod, otok.token_code};

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input accepted while two tokens wait");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:0] <= 6'd50))
        else $error("token code out of range");

    a_eof_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[5:0] == cltok_pkg::K_EOF) |-> m_axis_tlast)
        else $error("EOF token not last of its byte");

endmodule

// ===== rtl/core/cltok_digit.sv =====
// ============================================================================
// cltok_digit: one-digit accumulate step
// Computes acc * base + digit with range and overflow detection.
// ============================================================================
module cltok_digit
(
    input  logic [63:0] acc,
    input  logic [4:0]  base,
    input  logic [4:0]  digit,
    output logic [63:0] acc_out,
    output logic        bad_digit,
    output logic        overflow
);

    logic [4:0]  b;
    logic [3:0]  d;
    logic [68:0] prod;
    logic [69:0] sum;

    always_comb
    begin
        b         = (base == 5'd0) ? 5'd10 : base;
        bad_digit = (digit >= b);
        d         = bad_digit ? 4'd0 : digit[3:0];
        prod      = acc * b;
        sum       = {1'b0, prod} + {66'd0, d};
        overflow  = (sum[69:64] != 6'd0);
        acc_out   = overflow ? 64'd0 : sum[63:0];
    end

endmodule

// ===== rtl/core/cltok_fsm.sv =====
// ============================================================================
// cltok_fsm: scanner state and per-byte decision logic
// Holds the scan state and produces up to two tokens per accepted byte.
// ============================================================================
module cltok_fsm #(
    parameter int OFFSET_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            c,
    output logic [1:0]            n_tok,
    output cltok_pkg::token_t     tok0,
    output cltok_pkg::token_t     tok1
);

    localparam int OW = OFFSET_WIDTH;

    cltok_pkg::mode_t mode_reg, mode_next;
    logic [5:0]  kind_reg, kind_next;
    logic [63:0] acc_reg, acc_next;
    logic [4:0]  base_reg, base_next;
    logic [2:0]  mod_reg, mod_next;
    logic [OW-1:0] start_reg, start_next;
    logic [OW-1:0] pos_reg, pos_next;
    logic [3:0]  ferr_reg, ferr_next;
    logic [3:0]  rerr_reg, rerr_next;

    logic [OW-1:0] pos, nxt;
    logic [63:0] dg_acc;
    logic [4:0]  dg_digit;
    logic        dg_bad, dg_ovf;
    logic        fresh, eof_seen;
    logic [5:0]  k;
    logic [8:0]  ev;
    logic [4:0]  hv;

    cltok_digit u_digit
    (
        .acc       (acc_reg),
        .base      (base_reg),
        .digit     (dg_digit),
        .acc_out   (dg_acc),
        .bad_digit (dg_bad),
        .overflow  (dg_ovf)
    );

    function automatic logic [15:0] off16(input logic [OW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    always_comb
    begin
        hv = cltok_pkg::hex_val(c);
        dg_digit = (mode_reg == cltok_pkg::M_INT) ? hv : 5'(c - 8'h30);
        if (mode_reg != cltok_pkg::M_INT && !cltok_pkg::is_dig(c))
        begin
            dg_digit = hv;
        end
    end

    always_comb
    begin
        logic [3:0] ferr;
        logic [1:0] n;
        cltok_pkg::token_t t0, t1, tp;
        logic        emit;
        logic [5:0]  ek;
        logic [2:0]  em;
        logic [63:0] evv;
        logic [OW-1:0] ee;

        pos = pos_reg;
        nxt = pos_reg + OW'(1);
        mode_next = mode_reg;
        kind_next = kind_reg;
        acc_next = acc_reg;
        base_next = base_reg;
        mod_next = mod_reg;
        start_next = start_reg;
        rerr_next = rerr_reg;
        ferr = ferr_reg;
        fresh = 1'b0;
        eof_seen = 1'b0;
        emit = 1'b0;
        ek = cltok_pkg::K_EOF;
        em = cltok_pkg::MOD_NONE;
        evv = 64'd0;
        ee = pos;
        k = cltok_pkg::K_NONE;
        ev = cltok_pkg::esc_val(c);
        tp = '0;

        case (mode_reg)
            cltok_pkg::M_NAME:
            begin
                if (!(cltok_pkg::is_alpha(c) || cltok_pkg::is_dig(c)))
                begin
                    emit = 1'b1; ek = cltok_pkg::K_NAME; fresh = 1'b1;
                end
            end
            cltok_pkg::M_DOT:
            begin
                if (cltok_pkg::is_dig(c)) mode_next = cltok_pkg::M_FRAC;
                else
                begin
                    emit = 1'b1; ek = cltok_pkg::K_DOT; fresh = 1'b1;
                end
            end
            cltok_pkg::M_ZERO, cltok_pkg::M_RUN, cltok_pkg::M_RUN_OVF:
            begin
                if (mode_reg == cltok_pkg::M_ZERO && (c == 8'h78 || c == 8'h58))
                begin
                    mode_next = cltok_pkg::M_INT; base_next = 5'd16;
                    mod_next = cltok_pkg::MOD_HEX;
                end
                else if (mode_reg == cltok_pkg::M_ZERO && (c == 8'h62 || c == 8'h42))
                begin
                    mode_next = cltok_pkg::M_INT; base_next = 5'd2;
                    mod_next = cltok_pkg::MOD_BIN;
                end
                else if (c == 8'h2e || c == 8'h65 || c == 8'h45)
                begin
                    mode_next = (c == 8'h2e) ? cltok_pkg::M_FRAC : cltok_pkg::M_EXP0;
                    acc_next = 64'd0; mod_next = cltok_pkg::MOD_NONE;
                    rerr_next = cltok_pkg::E_NONE;
                end
                else if (cltok_pkg::is_dig(c))
                begin
                    if (mode_reg == cltok_pkg::M_ZERO)
                    begin
                        // Leading zero: octal; the digit value is 0..9 and acc is 0.
                        mode_next = cltok_pkg::M_RUN; base_next = 5'd8;
                        mod_next = cltok_pkg::MOD_OCT;
                        if (c >= 8'h38)
                        begin
                            if (rerr_reg == cltok_pkg::E_NONE) rerr_next = cltok_pkg::E_DIGIT;
                            acc_next = 64'd0;
                        end
                        else acc_next = 64'(c - 8'h30);
                    end
                    else if (mode_reg == cltok_pkg::M_RUN)
                    begin
                        if (dg_bad && rerr_reg == cltok_pkg::E_NONE)
                            rerr_next = cltok_pkg::E_DIGIT;
                        if (dg_ovf)
                        begin
                            if (!dg_bad && rerr_reg == cltok_pkg::E_NONE)
                                rerr_next = cltok_pkg::E_OVF;
                            mode_next = cltok_pkg::M_RUN_OVF;
                        end
                        acc_next = dg_acc;
                    end
                end
                else
                begin
                    if (ferr == cltok_pkg::E_NONE) ferr = rerr_reg;
                    if (mode_reg == cltok_pkg::M_RUN_OVF)
                    begin
                        emit = 1'b1; ek = cltok_pkg::K_INT; em = mod_reg; evv = acc_reg;
                        fresh = 1'b1;
                    end
                    else
                    begin
                        mode_next = cltok_pkg::M_INT;
                        if (hv > 5'd15)
                        begin
                            emit = 1'b1; ek = cltok_pkg::K_INT; em = mod_reg;
                            evv = acc_reg; fresh = 1'b1;
                        end
                        else
                        begin
                            if (dg_bad && ferr == cltok_pkg::E_NONE) ferr = cltok_pkg::E_DIGIT;
                            if (dg_ovf)
                            begin
                                if (ferr == cltok_pkg::E_NONE) ferr = cltok_pkg::E_OVF;
                                emit = 1'b1; ek = cltok_pkg::K_INT; em = mod_reg;
                                evv = 64'd0; fresh = 1'b1;
                            end
                            else acc_next = dg_acc;
                        end
                    end
                end
            end
            cltok_pkg::M_INT:
            begin
                if (hv > 5'd15)
                begin
                    emit = 1'b1; ek = cltok_pkg::K_INT; em = mod_reg; evv = acc_reg;
                    fresh = 1'b1;
                end
                else
                begin
                    if (dg_bad && ferr == cltok_pkg::E_NONE) ferr = cltok_pkg::E_DIGIT;
                    if (dg_ovf)
                    begin
                        if (ferr == cltok_pkg::E_NONE) ferr = cltok_pkg::E_OVF;
                        acc_next = 64'd0;
                        if (cltok_pkg::is_dig(c)) mode_next = cltok_pkg::M_INT_SKIP;
                        else
                        begin
                            emit = 1'b1; ek = cltok_pkg::K_INT; em = mod_reg;
                            evv = 64'd0; fresh = 1'b1;
                        end
                    end
                    else acc_next = dg_acc;
                end
            end
            cltok_pkg::M_INT_SKIP:
            begin
                if (!cltok_pkg::is_dig(c))
                begin
                    emit = 1'b1; ek = cltok_pkg::K_INT; em = mod_reg; evv = acc_reg;
                    fresh = 1'b1;
                end
            end
            cltok_pkg::M_FRAC, cltok_pkg::M_EXPD:
            begin
                if (!cltok_pkg::is_dig(c))
                begin
                    if (mode_reg == cltok_pkg::M_FRAC && (c == 8'h65 || c == 8'h45))
                        mode_next = cltok_pkg::M_EXP0;
                    else
                    begin
                        emit = 1'b1; ek = cltok_pkg::K_FLOAT; fresh = 1'b1;
                    end
                end
            end
            cltok_pkg::M_EXP0, cltok_pkg::M_EXP1:
            begin
                if (cltok_pkg::is_dig(c)) mode_next = cltok_pkg::M_EXPD;
                else if (mode_reg == cltok_pkg::M_EXP0 && (c == 8'h2b || c == 8'h2d))
                    mode_next = cltok_pkg::M_EXP1;
                else
                begin
                    if (ferr == cltok_pkg::E_NONE) ferr = cltok_pkg::E_NO_EXP;
                    emit = 1'b1; ek = cltok_pkg::K_FLOAT; fresh = 1'b1;
                end
            end
            cltok_pkg::M_CH_OPEN:
            begin
                if (c == 8'h27)
                begin
                    if (ferr == cltok_pkg::E_NONE) ferr = cltok_pkg::E_EMPTY_CH;
                    acc_next = 64'd0; mode_next = cltok_pkg::M_CH_CLOSE;
                end
                else if (c == 8'h0a || c == 8'h00)
                begin
                    if (ferr == cltok_pkg::E_NONE)
                        ferr = (c == 8'h0a) ? cltok_pkg::E_NL_CH : cltok_pkg::E_NO_CLOSE;
                    emit = 1'b1; ek = cltok_pkg::K_INT; em = mod_reg; evv = acc_reg;
                    fresh = 1'b1;
                end
                else if (c == 8'h5c) mode_next = cltok_pkg::M_CH_ESC;
                else
                begin
                    acc_next = 64'(c); mode_next = cltok_pkg::M_CH_CLOSE;
                end
            end
            cltok_pkg::M_CH_ESC:
            begin
                if (c == 8'h00)
                begin
                    if (ferr == cltok_pkg::E_NONE) ferr = cltok_pkg::E_BAD_ESC;
                    emit = 1'b1; ek = cltok_pkg::K_INT; em = mod_reg; evv = acc_reg;
                    fresh = 1'b1;
                end
                else
                begin
                    if (!ev[8] && ferr == cltok_pkg::E_NONE) ferr = cltok_pkg::E_BAD_ESC;
                    acc_next = 64'(ev[7:0]); mode_next = cltok_pkg::M_CH_CLOSE;
                end
            end
            cltok_pkg::M_CH_CLOSE:
            begin
                emit = 1'b1; ek = cltok_pkg::K_INT; em = mod_reg; evv = acc_reg;
                if (c == 8'h27) ee = nxt;
                else
                begin
                    if (ferr == cltok_pkg::E_NONE) ferr = cltok_pkg::E_NO_CLOSE;
                    fresh = 1'b1;
                end
            end
            cltok_pkg::M_ST_BODY:
            begin
                if (c == 8'h22)
                begin
                    emit = 1'b1; ek = cltok_pkg::K_STR; ee = nxt;
                end
                else if (c == 8'h00 || c == 8'h0a)
                begin
                    if (ferr == cltok_pkg::E_NONE)
                        ferr = (c == 8'h00) ? cltok_pkg::E_EOF_STR : cltok_pkg::E_NL_STR;
                    emit = 1'b1; ek = cltok_pkg::K_STR; fresh = 1'b1;
                end
                else if (c == 8'h5c) mode_next = cltok_pkg::M_ST_ESC;
            end
            cltok_pkg::M_ST_ESC:
            begin
                if (c == 8'h00)
                begin
                    if (ferr == cltok_pkg::E_NONE) ferr = cltok_pkg::E_BAD_ESC;
                    emit = 1'b1; ek = cltok_pkg::K_STR; fresh = 1'b1;
                end
                else
                begin
                    if (!ev[8] && ferr == cltok_pkg::E_NONE) ferr = cltok_pkg::E_BAD_ESC;
                    mode_next = cltok_pkg::M_ST_BODY;
                end
            end
            cltok_pkg::M_OP:
            begin
                k = cltok_pkg::op_next(kind_reg, c);
                if (k == cltok_pkg::K_LSHIFT || k == cltok_pkg::K_RSHIFT) kind_next = k;
                else if (k != cltok_pkg::K_NONE)
                begin
                    emit = 1'b1; ek = k; ee = nxt;
                end
                else
                begin
                    emit = 1'b1; ek = kind_reg; fresh = 1'b1;
                end
            end
            default:
            begin
                mode_next = cltok_pkg::M_IDLE;
                fresh = 1'b1;
            end
        endcase

        n = 2'd0;
        t0 = '0;
        t1 = '0;
        if (emit)
        begin
            t0.token_code = ek;
            t0.literal_mod = em;
            t0.int_value = evv;
            t0.start_offset = off16(start_reg);
            t0.end_offset = off16(ee);
            t0.error_code = ferr;
            n = 2'd1;
            ferr = cltok_pkg::E_NONE;
            mode_next = cltok_pkg::M_IDLE;
        end

        if (fresh)
        begin
            start_next = pos;
            tp.start_offset = off16(pos);
            tp.end_offset = off16(nxt);
            if (c == 8'h00)
            begin
                tp.token_code = cltok_pkg::K_EOF;
                tp.error_code = ferr;
                ferr = cltok_pkg::E_NONE;
                mode_next = cltok_pkg::M_IDLE;
                eof_seen = 1'b1;
                if (n == 2'd0) t0 = tp; else t1 = tp;
                n = n + 2'd1;
            end
            else if (!cltok_pkg::is_space(c))
            begin
                acc_next = 64'd0;
                mod_next = cltok_pkg::MOD_NONE;
                base_next = 5'd10;
                rerr_next = cltok_pkg::E_NONE;
                if (cltok_pkg::is_alpha(c)) mode_next = cltok_pkg::M_NAME;
                else if (c == 8'h30) mode_next = cltok_pkg::M_ZERO;
                else if (cltok_pkg::is_dig(c))
                begin
                    mode_next = cltok_pkg::M_RUN; acc_next = 64'(c - 8'h30);
                end
                else if (c == 8'h2e) mode_next = cltok_pkg::M_DOT;
                else if (c == 8'h27)
                begin
                    mode_next = cltok_pkg::M_CH_OPEN; mod_next = cltok_pkg::MOD_CHAR;
                end
                else if (c == 8'h22) mode_next = cltok_pkg::M_ST_BODY;
                else if (cltok_pkg::single_kind(c) != cltok_pkg::K_NONE)
                begin
                    tp.token_code = cltok_pkg::single_kind(c);
                    tp.error_code = ferr;
                    ferr = cltok_pkg::E_NONE;
                    mode_next = cltok_pkg::M_IDLE;
                    if (n == 2'd0) t0 = tp; else t1 = tp;
                    n = n + 2'd1;
                end
                else if (cltok_pkg::op_kind(c) != cltok_pkg::K_NONE)
                begin
                    mode_next = cltok_pkg::M_OP; kind_next = cltok_pkg::op_kind(c);
                end
                else if (ferr == cltok_pkg::E_NONE) ferr = cltok_pkg::E_BAD_CHAR;
            end
        end

        ferr_next = ferr;
        pos_next = eof_seen ? '0 : nxt;
        n_tok = n;
        tok0 = t0;
        tok1 = t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= cltok_pkg::M_IDLE;
            kind_reg  <= 6'd0;
            acc_reg   <= 64'd0;
            base_reg  <= 5'd10;
            mod_reg   <= cltok_pkg::MOD_NONE;
            start_reg <= '0;
            pos_reg   <= '0;
            ferr_reg  <= cltok_pkg::E_NONE;
            rerr_reg  <= cltok_pkg::E_NONE;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            kind_reg  <= kind_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            mod_reg   <= mod_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            ferr_reg  <= ferr_next;
            rerr_reg  <= rerr_next;
        end
    end

endmodule

// ===== rtl/core/cltok_outq.sv =====
// ============================================================================
// cltok_outq: result buffer
// Holds up to two tokens of one byte and drains them one per handshake.
// ============================================================================
module cltok_outq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [1:0]         n_in,
    input  cltok_pkg::token_t  tok0,
    input  cltok_pkg::token_t  tok1,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_ready,
    output cltok_pkg::token_t  out_tok,
    output logic               out_last
);

    logic [1:0]        cnt_reg, cnt_next;
    cltok_pkg::token_t t0_reg, t1_reg;
    logic              pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign can_load  = (cnt_reg == 2'd0) || (pop && cnt_reg == 2'd1);
    assign out_tok   = t0_reg;
    assign out_last  = (cnt_reg == 2'd1);

    always_comb
    begin
        cnt_next = cnt_reg - (pop ? 2'd1 : 2'd0);
        if (load) cnt_next = n_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cnt_reg <= 2'd0;
        else cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            t0_reg <= tok0;
            t1_reg <= tok1;
        end
        else if (pop)
        begin
            t0_reg <= t1_reg;
        end
    end

endmodule
